### rtl/core/uud_pkg.sv
// ============================================================================
// uud_pkg
// Shared types, character codes and UTF-8 helpers for the URI unescape core.
// ============================================================================
package uud_pkg;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_U_LOWER  = 8'h75;
    localparam logic [7:0] CH_U_UPPER  = 8'h55;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;

    // Code point limits for the UTF-8 length.
    localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;

    // UTF-8 lead and continuation marks.
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // Escape collection counts.
    localparam logic [2:0] DIGITS_SHORT = 3'd2;
    localparam logic [2:0] DIGITS_LONG  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PCT     = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    // One decoded unit: a code point to be encoded, or the string terminator.
    typedef struct packed {
        logic        term;
        logic [15:0] cp;
    } item_t;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
        begin
            r = {1'b1, 4'(c - CH_DIGIT_0)};
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        end
        return r;
    endfunction

    // Number of output bytes for an item, 1 to 3.
    function automatic logic [1:0] utf8_len(input item_t it);
        logic [1:0] n;
        if (it.term || it.cp < CP_ONE_LIMIT)
        begin
            n = 2'd1;
        end
        else if (it.cp < CP_TWO_LIMIT)
        begin
            n = 2'd2;
        end
        else
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Output byte number idx of an item.
    function automatic logic [7:0] utf8_byte(input item_t it, input logic [1:0] idx);
        logic [7:0] b;
        logic [1:0] n;
        n = utf8_len(it);
        b = it.cp[7:0];
        if (it.term)
        begin
            b = CH_NUL;
        end
        else if (n == 2'd2)
        begin
            b = (idx == 2'd0) ? (UTF8_LEAD2 | {3'b000, it.cp[10:6]})
                              : (UTF8_CONT | {2'b00, it.cp[5:0]});
        end
        else if (n == 2'd3)
        begin
            if (idx == 2'd0)
            begin
                b = UTF8_LEAD3 | {4'b0000, it.cp[15:12]};
            end
            else if (idx == 2'd1)
            begin
                b = UTF8_CONT | {2'b00, it.cp[11:6]};
            end
            else
            begin
                b = UTF8_CONT | {2'b00, it.cp[5:0]};
            end
        end
        return b;
    endfunction

endpackage

### rtl/core/uud_front.sv
// ============================================================================
// uud_front
// Accepts input bytes, tracks percent escapes and pushes decoded units.
// ============================================================================
module uud_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      in_byte,
    input  logic            q_full,
    output logic            push,
    output uud_pkg::item_t  push_item
);

    uud_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      digits_left_reg, digits_left_next;
    logic [15:0]     code_value_reg, code_value_next;
    logic            still_hex_reg, still_hex_next;

    logic            fire;
    logic            emit;
    logic [4:0]      hd;
    logic [15:0]     col_code_in;
    logic            col_hex_in;
    logic [2:0]      col_left_in;
    logic [15:0]     col_code;
    logic            col_hex;
    logic [2:0]      col_left;
    logic [7:0]      plain;

    assign in_stall = q_full;
    assign fire     = in_valid && !in_stall;
    assign push     = fire && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= uud_pkg::PH_IDLE;
            digits_left_reg <= 3'd0;
            code_value_reg  <= 16'd0;
            still_hex_reg   <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            digits_left_reg <= digits_left_next;
            code_value_reg  <= code_value_next;
            still_hex_reg   <= still_hex_next;
        end
    end

    always_comb
    begin
        hd = uud_pkg::hex_digit(in_byte);

        // Collection step, fed either by a fresh escape or by the open one.
        if (phase_reg == uud_pkg::PH_PCT)
        begin
            col_code_in = 16'd0;
            col_hex_in  = 1'b1;
            col_left_in = uud_pkg::DIGITS_SHORT;
        end
        else
        begin
            col_code_in = code_value_reg;
            col_hex_in  = still_hex_reg;
            col_left_in = (digits_left_reg == 3'd0 || digits_left_reg > uud_pkg::DIGITS_LONG)
                          ? 3'd1 : digits_left_reg;
        end
        col_hex  = col_hex_in && hd[4];
        col_code = col_hex ? {col_code_in[11:0], hd[3:0]} : col_code_in;
        col_left = col_left_in - 3'd1;

        plain = (in_byte < uud_pkg::CH_SPACE || in_byte > uud_pkg::CH_DEL)
                ? uud_pkg::CH_QUESTION : in_byte;

        phase_next       = phase_reg;
        digits_left_next = digits_left_reg;
        code_value_next  = code_value_reg;
        still_hex_next   = still_hex_reg;
        emit             = 1'b0;
        push_item.term   = 1'b0;
        push_item.cp     = 16'd0;

        if (in_byte == uud_pkg::CH_NUL)
        begin
            // The terminator drops any open escape and resets the parser.
            phase_next       = uud_pkg::PH_IDLE;
            digits_left_next = 3'd0;
            code_value_next  = 16'd0;
            still_hex_next   = 1'b1;
            emit             = 1'b1;
            push_item.term   = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                uud_pkg::PH_PCT, uud_pkg::PH_COLLECT:
                begin
                    if (phase_reg == uud_pkg::PH_PCT &&
                        (in_byte == uud_pkg::CH_U_LOWER || in_byte == uud_pkg::CH_U_UPPER))
                    begin
                        phase_next       = uud_pkg::PH_COLLECT;
                        digits_left_next = uud_pkg::DIGITS_LONG;
                        code_value_next  = 16'd0;
                        still_hex_next   = 1'b1;
                    end
                    else if (col_left != 3'd0)
                    begin
                        phase_next       = uud_pkg::PH_COLLECT;
                        digits_left_next = col_left;
                        code_value_next  = col_code;
                        still_hex_next   = col_hex;
                    end
                    else
                    begin
                        phase_next       = uud_pkg::PH_IDLE;
                        digits_left_next = 3'd0;
                        code_value_next  = 16'd0;
                        still_hex_next   = 1'b1;
                        emit             = 1'b1;
                        push_item.cp     = col_code;
                    end
                end
                default:
                begin
                    if (in_byte == uud_pkg::CH_PERCENT)
                    begin
                        phase_next = uud_pkg::PH_PCT;
                    end
                    else
                    begin
                        phase_next   = uud_pkg::PH_IDLE;
                        emit         = 1'b1;
                        push_item.cp = {8'd0, plain};
                    end
                end
            endcase
        end
    end

endmodule

### rtl/core/uud_queue.sv
// ============================================================================
// uud_queue
// Short FIFO of decoded units between the front and back parts.
// ============================================================================
module uud_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  uud_pkg::item_t  push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output uud_pkg::item_t  head
);

    uud_pkg::item_t                entries_reg [uud_pkg::QDEPTH];
    logic [uud_pkg::QIDX_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [uud_pkg::QIDX_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [uud_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full  = (count_reg == uud_pkg::QCNT_W'(uud_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == uud_pkg::QIDX_W'(uud_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + uud_pkg::QIDX_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == uud_pkg::QIDX_W'(uud_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + uud_pkg::QIDX_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + uud_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - uud_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/uud_back.sv
// ============================================================================
// uud_back
// Encodes units as UTF-8 into the output register: a byte a cycle unless stalled.
// ============================================================================
module uud_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  uud_pkg::item_t  head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic            string_end
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       end_reg;

    logic       load;
    logic [1:0] len;
    logic       is_last;

    assign len     = uud_pkg::utf8_len(head);
    assign is_last = (idx_reg == len - 2'd1);
    assign load    = !q_empty && (!out_valid_reg || !out_stall);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= uud_pkg::utf8_byte(head, idx_reg);
            last_reg     <= is_last;
            end_reg      <= head.term;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign string_end  = end_reg;

endmodule

### rtl/core/uri_unescape_to_utf8_core.sv
// ============================================================================
// uri_unescape_to_utf8_core
// URI percent decoder with %uXXXX support, producing a UTF-8 byte stream.
// ============================================================================
// Usage: feed the URI one byte per transfer on in_valid/in_stall/in_byte; a
// zero byte ends the string and comes out as a single transfer with
// string_end and last_of_run set. Each input byte gives zero results (it is
// part of an escape still open) or one to three output transfers on
// out_valid/out_stall, with last_of_run set on the final one.
// The first output byte of an input passes through a queue entry and the
// output register before it is presented. The front part takes one input
// byte per cycle while the queue is not full; the back part drives one
// output byte per cycle from a registered output unless out_stall holds it,
// so a code point of two or three UTF-8 bytes occupies the output while each
// of its bytes goes out. A four-entry queue between the parts absorbs that
// and any output stall; in_stall rises only when the queue is full.
// Reset clears the escape parser, empties the queue and drops out_valid.
// While out_stall is high the presented byte and flags hold.
module uri_unescape_to_utf8_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       string_end
);

    logic           push;
    uud_pkg::item_t push_item;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    uud_pkg::item_t head;

    uud_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    uud_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    uud_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .string_end  (string_end)
    );

endmodule

### rtl/core/uud_checker.sv
// ============================================================================
// uud_checker
// Port-level checks on the output stream of the URI unescape core.
// ============================================================================
module uud_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       string_end
);

    // A stalled output transfer holds until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) &&
            $stable(last_of_run) && $stable(string_end))
        else $error("output changed while stalled");

    // The terminator is a lone zero byte.
    a_term_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> last_of_run && out_byte == 8'h00)
        else $error("terminator transfer malformed");

    // Any byte before the last of a run belongs to a multi-byte sequence.
    a_multi_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> out_byte[7])
        else $error("non-final byte without high bit");

    // A final byte with the high bit set closes a sequence as a continuation byte.
    a_last_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run && out_byte[7] |-> out_byte[7:6] == 2'b10)
        else $error("final byte of a sequence is not a continuation byte");

endmodule

bind uri_unescape_to_utf8_core uud_checker u_uud_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .string_end  (string_end)
);

### tb/unescape_tb_pkg.sv
// ============================================================================
// unescape_tb_pkg
// Scoreboard for the URI unescape core: predicts the UTF-8 byte stream of
// each accepted character and checks every output transfer against it.
// ============================================================================
package unescape_tb_pkg;

    import uud_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ends_string;
    } utf8_byte_t;

    class unescape_scoreboard;

        phase_t      phase;
        logic [2:0]  digits_left;
        logic [15:0] code_point;
        bit          all_hex;

        utf8_byte_t  pending_bytes[$];
        int          chars_in;
        int          bytes_checked;
        int          mismatches;

        function new();
            clear_escape();
            chars_in = 0;
            bytes_checked = 0;
            mismatches = 0;
        endfunction

        function void clear_escape();
            phase = PH_IDLE;
            digits_left = 3'd0;
            code_point = 16'h0000;
            all_hex = 1'b1;
        endfunction

        function bit decode_hex(input logic [7:0] c, output logic [3:0] v);
            v = 4'h0;
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            begin
                v = 4'(c - CH_DIGIT_0);
                return 1'b1;
            end
            if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            begin
                v = 4'(c - CH_LOWER_A + 8'd10);
                return 1'b1;
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            begin
                v = 4'(c - CH_UPPER_A + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push_byte(input logic [7:0] data, input logic last);
            utf8_byte_t b;
            b.data = data;
            b.last = last;
            b.ends_string = 1'b0;
            pending_bytes.push_back(b);
        endfunction

        // One character of an open escape; a code point leaves once the count runs out.
        function void collect_char(input logic [7:0] c);
            logic [3:0]  v;
            logic [15:0] cp;
            bit          is_hex;
            is_hex = decode_hex(c, v);
            if (all_hex && is_hex)
            begin
                code_point = {code_point[11:0], v};
            end
            else
            begin
                all_hex = 1'b0;
            end
            if (digits_left != 3'd0)
            begin
                digits_left = digits_left - 3'd1;
            end
            if (digits_left != 3'd0)
            begin
                return;
            end
            cp = code_point;
            clear_escape();
            if (cp < 16'h0080)
            begin
                push_byte(cp[7:0], 1'b1);
            end
            else if (cp < 16'h0800)
            begin
                push_byte({3'b110, cp[10:6]}, 1'b0);
                push_byte({2'b10, cp[5:0]}, 1'b1);
            end
            else
            begin
                push_byte({4'b1110, cp[15:12]}, 1'b0);
                push_byte({2'b10, cp[11:6]}, 1'b0);
                push_byte({2'b10, cp[5:0]}, 1'b1);
            end
        endfunction

        function void accept_char(input logic [7:0] c);
            utf8_byte_t b;
            chars_in++;
            if (c == CH_NUL)
            begin
                // The terminator always closes the string, even inside an escape.
                clear_escape();
                b.data = CH_NUL;
                b.last = 1'b1;
                b.ends_string = 1'b1;
                pending_bytes.push_back(b);
                return;
            end
            case (phase)
                PH_PCT:
                begin
                    phase = PH_COLLECT;
                    code_point = 16'h0000;
                    all_hex = 1'b1;
                    if (c == CH_U_LOWER || c == CH_U_UPPER)
                    begin
                        digits_left = DIGITS_LONG;
                    end
                    else
                    begin
                        digits_left = DIGITS_SHORT;
                        collect_char(c);
                    end
                end
                PH_COLLECT:
                begin
                    if (digits_left == 3'd0 || digits_left > DIGITS_LONG)
                    begin
                        digits_left = 3'd1;
                    end
                    collect_char(c);
                end
                default:
                begin
                    phase = PH_IDLE;
                    if (c == CH_PERCENT)
                    begin
                        phase = PH_PCT;
                    end
                    else if (c < CH_SPACE || c > CH_DEL)
                    begin
                        push_byte(CH_QUESTION, 1'b1);
                    end
                    else
                    begin
                        push_byte(c, 1'b1);
                    end
                end
            endcase
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("%0t ns: mismatch: %s", $realtime, what);
        endtask

        task check_byte(input logic [7:0] data, input logic last, input logic ends_string);
            utf8_byte_t want;
            bytes_checked++;
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output byte %02h", data));
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data)
            begin
                report_mismatch($sformatf("out_byte %02h, expected %02h", data, want.data));
            end
            if (last !== want.last)
            begin
                report_mismatch($sformatf("last_of_run %b, expected %b", last, want.last));
            end
            if (ends_string !== want.ends_string)
            begin
                report_mismatch($sformatf("string_end %b, expected %b",
                                          ends_string, want.ends_string));
            end
        endtask

    endclass

endpackage

### tb/uri_unescape_to_utf8_core_tb.sv
// ============================================================================
// uri_unescape_to_utf8_core_tb
// Drives URI strings into the unescape core with random gaps and output
// stalls, and checks every output byte against a predicted UTF-8 stream.
// ============================================================================
module uri_unescape_to_utf8_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import uud_pkg::*;
    import unescape_tb_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_end;

    unescape_scoreboard sb;

    bit in_gappy;
    bit out_gappy;
    bit hold_request;
    bit hold_done;
    int input_stall_cycles;
    int random_chars;

    uri_unescape_to_utf8_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .string_end  (string_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

    // Offers one character and returns at the edge where its transfer happens.
    task send_char(input logic [7:0] c);
        int gap;
        if ($urandom_range(0, 29) == 0)
        begin
            in_gappy = !in_gappy;
        end
        gap = in_gappy ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= c;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
            begin
                break;
            end
            input_stall_cycles++;
        end
        sb.accept_char(c);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return CH_DIGIT_0 + 8'(v);
        end
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
    endfunction

    task send_counted(input logic [7:0] c);
        send_char(c);
        random_chars++;
    endtask

    // Mostly well-formed text and escapes, with some broken escapes and raw noise.
    task send_random_string();
        int pieces;
        int kind;
        int zeros;
        int n;
        pieces = $urandom_range(1, 12);
        repeat (pieces)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                send_counted(8'($urandom_range(32, 127)));
            end
            else if (kind < 65)
            begin
                send_counted(CH_PERCENT);
                send_counted(rand_hex_char());
                send_counted(rand_hex_char());
            end
            else if (kind < 80)
            begin
                send_counted(CH_PERCENT);
                send_counted($urandom_range(0, 1) ? CH_U_LOWER : CH_U_UPPER);
                zeros = $urandom_range(0, 3);
                for (int i = 0; i < 4; i++)
                begin
                    send_counted(i < zeros ? CH_DIGIT_0 : rand_hex_char());
                end
            end
            else if (kind < 90)
            begin
                send_counted(CH_PERCENT);
                n = $urandom_range(0, 3);
                repeat (n)
                begin
                    send_counted(8'($urandom_range(1, 255)));
                end
            end
            else
            begin
                send_counted(8'($urandom_range(1, 255)));
            end
        end
        send_counted(CH_NUL);
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    // Output side: random stalls per transfer, plus one long hold on request.
    initial
    begin
        int hold_cycles;
        hold_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_cycles = 150;
            end
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_byte(out_byte, last_of_run, string_end);
                if ($urandom_range(0, 39) == 0)
                begin
                    out_gappy = !out_gappy;
                end
                hold_cycles = out_gappy ? $urandom_range(0, 15) : 0;
            end
        end
    end

    initial
    begin
        sb = new();
        in_gappy = 1'b0;
        out_gappy = 1'b0;
        hold_request = 1'b0;
        hold_done = 1'b0;
        input_stall_cycles = 0;
        random_chars = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        out_stall = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: bytes that pass or become '?', one, two and three byte code
        // points, escapes broken by a non-hex character, and a string ending mid escape.
        send_char(CH_DEL);
        send_char(8'h80);
        send_char(8'hFF);
        send_char(8'h1F);
        send_text("%7e%UFFfF%ag%E9%-1%u1");
        send_char(CH_NUL);
        send_char(CH_NUL);

        in_gappy = 1'b1;
        out_gappy = 1'b1;
        while (random_chars < 300)
        begin
            if (!hold_done && random_chars > 100)
            begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            send_random_string();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("%0d characters sent in strings of plain text, escapes and noise;",
                 sb.chars_in);
        $display("%0d output bytes checked, input held off for %0d cycles.",
                 sb.bytes_checked, input_stall_cycles);
        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/uud_pkg.sv
rtl/core/uud_front.sv
rtl/core/uud_queue.sv
rtl/core/uud_back.sv
rtl/core/uri_unescape_to_utf8_core.sv
rtl/core/uud_checker.sv
tb/unescape_tb_pkg.sv
tb/uri_unescape_to_utf8_core_tb.sv
